>>> rtl/core/gpbe_pkg.sv
`timescale 1ns / 1ps

package gpbe_pkg;

    // Number of buttons with an auto-repeat timer (4 to 16)
    localparam int RepeatButtons = 12;
    localparam int DirTimers     = 4;

    // Pad id bytes
    localparam logic [7:0] PAD_DIGITAL  = 8'h41;
    localparam logic [7:0] PAD_ANALOG_S = 8'h73;
    localparam logic [7:0] PAD_ANALOG_Y = 8'h79;
    localparam logic [7:0] STICK_NEUTRAL = 8'd128;

    // Button word bit positions
    localparam logic [15:0] DPAD_MASK = 16'h00F0;
    localparam int DirUpBit    = 4;
    localparam int DirRightBit = 5;
    localparam int DirDownBit  = 6;
    localparam int DirLeftBit  = 7;

    // Config register indexes
    localparam logic [1:0] CFG_REPEAT_DELAY  = 2'd0;
    localparam logic [1:0] CFG_REPEAT_PERIOD = 2'd1;
    localparam logic [1:0] CFG_STICK_HIGH    = 2'd2;
    localparam logic [1:0] CFG_STICK_LOW     = 2'd3;

    // Config reset values
    localparam logic [7:0] RESET_DELAY      = 8'd7;
    localparam logic [7:0] RESET_PERIOD     = 8'd3;
    localparam logic [7:0] RESET_STICK_HIGH = 8'd192;
    localparam logic [7:0] RESET_STICK_LOW  = 8'd64;

    // Timer to button-bit mapping: up, down, left, right, then the rest
    localparam logic [3:0] TIMER_BIT [16] = '{
        4'd4,  4'd6,  4'd7,  4'd5,
        4'd10, 4'd8,  4'd11, 4'd9,
        4'd14, 4'd13, 4'd12, 4'd15,
        4'd0,  4'd1,  4'd2,  4'd3
    };

    // Per-item controls for the repeat timers
    typedef struct packed {
        logic        advance;
        logic [15:0] edges;
        logic [15:0] held;
        logic [15:0] vedges;
        logic [15:0] vheld;
        logic [7:0]  delay;
        logic [7:0]  period;
    } gpbe_tmr_ctl_t;

    typedef struct packed {
        logic [7:0] cnt;
        logic       pulse;
    } gpbe_tick_t;

    // One timer step: load on a press, count down while held, pulse at zero
    function automatic gpbe_tick_t tick_timer(
        input logic [7:0] cnt,
        input logic       press,
        input logic       hold,
        input logic [7:0] delay,
        input logic [7:0] period
    );
        gpbe_tick_t res;
        logic [7:0] dec;
        dec       = cnt - 8'd1;
        res.cnt   = cnt;
        res.pulse = 1'b0;
        if (press) begin
            res.cnt = delay;
        end else if (hold) begin
            if (dec == 8'd0) begin
                res.pulse = 1'b1;
                res.cnt   = period;
            end else begin
                res.cnt = dec;
            end
        end
        return res;
    endfunction

endpackage

>>> rtl/core/gpbe_repeat.sv
`timescale 1ns / 1ps

module gpbe_repeat (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  gpbe_pkg::gpbe_tmr_ctl_t ctl,
    output logic [15:0]            pulses,
    output logic [15:0]            vpulses
);

    logic [7:0] cnt_reg  [gpbe_pkg::RepeatButtons];
    logic [7:0] cnt_next [gpbe_pkg::RepeatButtons];

    // Physical pass for every timer, then a virtual pass for the directions
    always_comb begin
        gpbe_pkg::gpbe_tick_t t1;
        gpbe_pkg::gpbe_tick_t t2;
        logic [3:0] b;
        pulses  = '0;
        vpulses = '0;
        t1      = '0;
        t2      = '0;
        b       = '0;
        for (int i = 0; i < gpbe_pkg::RepeatButtons; i++) begin
            b  = gpbe_pkg::TIMER_BIT[i];
            t1 = gpbe_pkg::tick_timer(cnt_reg[i], ctl.edges[b], ctl.held[b],
                                      ctl.delay, ctl.period);
            pulses[b] = t1.pulse;
            if (i < gpbe_pkg::DirTimers) begin
                t2 = gpbe_pkg::tick_timer(t1.cnt, ctl.vedges[b], ctl.vheld[b],
                                          ctl.delay, ctl.period);
                vpulses[b]  = t2.pulse;
                cnt_next[i] = t2.cnt;
            end else begin
                cnt_next[i] = t1.cnt;
            end
        end
    end

    // Timers move only when a frame is retired
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < gpbe_pkg::RepeatButtons; i++) begin
                cnt_reg[i] <= '0;
            end
        end else if (ctl.advance) begin
            for (int i = 0; i < gpbe_pkg::RepeatButtons; i++) begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

endmodule

>>> rtl/core/gamepad_button_edge_autorepeat.sv
`timescale 1ns / 1ps

// Channel   Ports                       Direction  Moves
// s_        s_valid / s_ready + 8 bytes in         one controller frame request
// m_        m_valid / m_ready + 10 flds out        one result request per frame
// cfg_      cfg_wr_en, cfg_index, data  in         register write, no wait
//
// One frame per cycle sustained while m_ready stays high. A frame is held in
// the input register, is decoded and ticks the repeat timers in a single
// pass, and lands in the output register, which drives m_valid.
// Reset clears history, timers, valids and loads the register defaults.
// A stalled output holds its result while the input register still takes
// one more frame.

module gamepad_button_edge_autorepeat (
    input  logic        aclk,
    input  logic        aresetn,
    // input frames
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_read_status,
    input  logic [7:0]  s_pad_kind,
    input  logic [7:0]  s_button_high_byte,
    input  logic [7:0]  s_button_low_byte,
    input  logic [7:0]  s_right_stick_x,
    input  logic [7:0]  s_right_stick_y,
    input  logic [7:0]  s_left_stick_x,
    input  logic [7:0]  s_left_stick_y,
    // results
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_held_buttons,
    output logic [15:0] m_pressed_edges,
    output logic [15:0] m_pressed_with_repeat,
    output logic [15:0] m_virtual_held,
    output logic [15:0] m_virtual_edges,
    output logic [15:0] m_virtual_with_repeat,
    output logic [7:0]  m_out_right_x,
    output logic [7:0]  m_out_right_y,
    output logic [7:0]  m_out_left_x,
    output logic [7:0]  m_out_left_y,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    // Config registers
    logic [7:0] delay_reg, period_reg, high_reg, low_reg;

    // Input stage
    logic       in_valid_reg, in_valid_next;
    logic [7:0] status_reg, kind_reg, bhi_reg, blo_reg;
    logic [7:0] rx_in_reg, ry_in_reg, lx_in_reg, ly_in_reg;

    // History
    logic [15:0] prev_held_reg, prev_virtual_reg;

    // Output stage
    logic        out_valid_reg, out_valid_next;
    logic [15:0] held_reg, edges_reg, rep_reg, vheld_reg, vedges_reg, vrep_reg;
    logic [7:0]  rx_reg, ry_reg, lx_reg, ly_reg;

    // Decode results
    logic        analog, digital, advance, take;
    logic [15:0] held, prev, vheld, vprev, edges, vedges, pulses, vpulses;
    logic [7:0]  rx, ry, lx, ly;

    gpbe_pkg::gpbe_tmr_ctl_t tmr_ctl;

    // Handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign take    = s_valid && s_ready;

    assign in_valid_next  = take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg  <= gpbe_pkg::RESET_DELAY;
            period_reg <= gpbe_pkg::RESET_PERIOD;
            high_reg   <= gpbe_pkg::RESET_STICK_HIGH;
            low_reg    <= gpbe_pkg::RESET_STICK_LOW;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                gpbe_pkg::CFG_REPEAT_DELAY:  delay_reg  <= cfg_data;
                gpbe_pkg::CFG_REPEAT_PERIOD: period_reg <= cfg_data;
                gpbe_pkg::CFG_STICK_HIGH:    high_reg   <= cfg_data;
                gpbe_pkg::CFG_STICK_LOW:     low_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            status_reg <= s_read_status;
            kind_reg   <= s_pad_kind;
            bhi_reg    <= s_button_high_byte;
            blo_reg    <= s_button_low_byte;
            rx_in_reg  <= s_right_stick_x;
            ry_in_reg  <= s_right_stick_y;
            lx_in_reg  <= s_left_stick_x;
            ly_in_reg  <= s_left_stick_y;
        end
    end

    // Frame decode
    always_comb begin
        analog  = (status_reg == 8'd0) &&
                  ((kind_reg == gpbe_pkg::PAD_ANALOG_S) ||
                   (kind_reg == gpbe_pkg::PAD_ANALOG_Y));
        digital = analog || ((status_reg == 8'd0) && (kind_reg == gpbe_pkg::PAD_DIGITAL));
        held    = digital ? ~{bhi_reg, blo_reg} : 16'd0;
        prev    = digital ? prev_held_reg : 16'd0;
        vprev   = analog ? prev_virtual_reg : 16'd0;
        rx      = analog ? rx_in_reg : gpbe_pkg::STICK_NEUTRAL;
        ry      = analog ? ry_in_reg : gpbe_pkg::STICK_NEUTRAL;
        lx      = analog ? lx_in_reg : gpbe_pkg::STICK_NEUTRAL;
        ly      = analog ? ly_in_reg : gpbe_pkg::STICK_NEUTRAL;

        // Virtual d-pad from d-pad bits and left stick thresholds
        vheld = held & gpbe_pkg::DPAD_MASK;
        if (lx > high_reg) vheld[gpbe_pkg::DirRightBit] = 1'b1;
        if (lx < low_reg)  vheld[gpbe_pkg::DirLeftBit]  = 1'b1;
        if (ly > high_reg) vheld[gpbe_pkg::DirDownBit]  = 1'b1;
        if (ly < low_reg)  vheld[gpbe_pkg::DirUpBit]    = 1'b1;

        edges  = held & ~prev;
        vedges = vheld & ~vprev;
    end

    // Repeat timers
    always_comb begin
        tmr_ctl.advance = advance;
        tmr_ctl.edges   = edges;
        tmr_ctl.held    = held;
        tmr_ctl.vedges  = vedges;
        tmr_ctl.vheld   = vheld;
        tmr_ctl.delay   = delay_reg;
        tmr_ctl.period  = period_reg;
    end

    gpbe_repeat u_repeat (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (tmr_ctl),
        .pulses  (pulses),
        .vpulses (vpulses)
    );

    // History and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_held_reg    <= '0;
            prev_virtual_reg <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (advance) begin
                prev_held_reg    <= held;
                prev_virtual_reg <= vheld;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (advance) begin
            held_reg   <= held;
            edges_reg  <= edges;
            rep_reg    <= edges | pulses;
            vheld_reg  <= vheld;
            vedges_reg <= vedges;
            vrep_reg   <= vedges | vpulses;
            rx_reg     <= rx;
            ry_reg     <= ry;
            lx_reg     <= lx;
            ly_reg     <= ly;
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_held_buttons        = held_reg;
    assign m_pressed_edges       = edges_reg;
    assign m_pressed_with_repeat = rep_reg;
    assign m_virtual_held        = vheld_reg;
    assign m_virtual_edges       = vedges_reg;
    assign m_virtual_with_repeat = vrep_reg;
    assign m_out_right_x         = rx_reg;
    assign m_out_right_y         = ry_reg;
    assign m_out_left_x          = lx_reg;
    assign m_out_left_y          = ly_reg;

endmodule

>>> sim/gamepad_button_edge_autorepeat_tb.sv
`timescale 1ns / 1ps

module gamepad_button_edge_autorepeat_tb;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int PHASES         = 8;
    localparam int RANDOM_PHASE   = 4;
    localparam int FRAMES_PER_SET = 250;
    localparam int DRAIN_CYCLES   = 4;

    // Idle patterns, one per phase in turn
    localparam int IDLE_NONE     = 0;
    localparam int IDLE_SENDER   = 1;
    localparam int IDLE_RECEIVER = 2;
    localparam int IDLE_BOTH     = 3;

    // Button bit served by each repeat timer: directions first
    localparam int REPEAT_POS [16] = '{
        gpbe_pkg::DirUpBit, gpbe_pkg::DirDownBit, gpbe_pkg::DirLeftBit, gpbe_pkg::DirRightBit,
        10, 8, 11, 9, 14, 13, 12, 15, 0, 1, 2, 3
    };

    typedef struct packed {
        logic [7:0] status;
        logic [7:0] kind;
        logic [7:0] btn_hi;
        logic [7:0] btn_lo;
        logic [7:0] rx;
        logic [7:0] ry;
        logic [7:0] lx;
        logic [7:0] ly;
    } frame_t;

    typedef struct packed {
        logic [15:0] held;
        logic [15:0] edges;
        logic [15:0] rep;
        logic [15:0] vheld;
        logic [15:0] vedges;
        logic [15:0] vrep;
        logic [7:0]  rx;
        logic [7:0]  ry;
        logic [7:0]  lx;
        logic [7:0]  ly;
    } result_t;

    typedef struct packed {
        frame_t  f;
        logic    typed;
        result_t r;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] delay;
        logic [7:0] period;
        logic [7:0] high;
        logic [7:0] low;
    } reg_set_t;

    localparam result_t UNTYPED     = '0;
    localparam result_t IDLE_RESULT = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                        16'h0000, 8'd128, 8'd128, 8'd128, 8'd128};
    localparam result_t ALL_PRESSED = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00F0, 16'h00F0,
                                        16'h00F0, 8'd128, 8'd128, 8'd128, 8'd128};

    localparam frame_t PRESS_ALL = '{8'h00, gpbe_pkg::PAD_DIGITAL, 8'h00, 8'h00,
                                     8'h00, 8'h00, 8'h00, 8'h00};
    localparam frame_t STICK_RU  = '{8'h00, gpbe_pkg::PAD_ANALOG_S, 8'hFF, 8'hFF,
                                     8'hFF, 8'h00, 8'hFF, 8'h00};

    // Directed frames; expected values typed only where they are obvious
    localparam int DIRECTED_COUNT = 25;
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{'{8'hFF, gpbe_pkg::PAD_DIGITAL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
          1'b1, IDLE_RESULT},
        '{'{8'h00, gpbe_pkg::PAD_DIGITAL, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF},
          1'b1, IDLE_RESULT},
        '{PRESS_ALL, 1'b1, ALL_PRESSED},
        '{PRESS_ALL, 1'b0, UNTYPED},
        '{PRESS_ALL, 1'b0, UNTYPED},
        '{PRESS_ALL, 1'b0, UNTYPED},
        '{PRESS_ALL, 1'b0, UNTYPED},
        '{PRESS_ALL, 1'b0, UNTYPED},
        '{PRESS_ALL, 1'b0, UNTYPED},
        '{PRESS_ALL, 1'b0, UNTYPED},
        '{PRESS_ALL, 1'b0, UNTYPED},
        '{STICK_RU, 1'b0, UNTYPED},
        '{STICK_RU, 1'b0, UNTYPED},
        '{STICK_RU, 1'b0, UNTYPED},
        '{STICK_RU, 1'b0, UNTYPED},
        '{STICK_RU, 1'b0, UNTYPED},
        '{STICK_RU, 1'b0, UNTYPED},
        '{STICK_RU, 1'b0, UNTYPED},
        '{STICK_RU, 1'b0, UNTYPED},
        // d-pad up shared with stick left/down: timer counts twice
        '{'{8'h00, gpbe_pkg::PAD_ANALOG_Y, 8'hFE, 8'hEF, 8'h00, 8'hFF, 8'h00, 8'hFF},
          1'b0, UNTYPED},
        // sticks exactly on the thresholds do not trigger
        '{'{8'h00, gpbe_pkg::PAD_ANALOG_Y, 8'hFE, 8'hEF, 8'h80, 8'h80, 8'hC0, 8'h40},
          1'b0, UNTYPED},
        '{'{8'h00, gpbe_pkg::PAD_ANALOG_Y, 8'hFE, 8'hEF, 8'h80, 8'h80, 8'hC1, 8'h3F},
          1'b0, UNTYPED},
        // bad status, unknown ids
        '{'{8'h01, gpbe_pkg::PAD_ANALOG_S, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
          1'b1, IDLE_RESULT},
        '{'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, IDLE_RESULT},
        '{'{8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, IDLE_RESULT}
    };

    // Register settings per phase; the random phase draws its own
    localparam reg_set_t REG_PHASES [PHASES] = '{
        '{8'd7,   8'd3,   8'd192, 8'd64},
        '{8'd1,   8'd1,   8'd0,   8'd255},
        '{8'd255, 8'd255, 8'd255, 8'd0},
        '{8'd2,   8'd5,   8'd200, 8'd50},
        '{8'd7,   8'd3,   8'd192, 8'd64},
        '{8'd1,   8'd255, 8'd128, 8'd128},
        '{8'd255, 8'd1,   8'd127, 8'd129},
        '{8'd7,   8'd3,   8'd192, 8'd64}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_read_status;
    logic [7:0]  s_pad_kind;
    logic [7:0]  s_button_high_byte;
    logic [7:0]  s_button_low_byte;
    logic [7:0]  s_right_stick_x;
    logic [7:0]  s_right_stick_y;
    logic [7:0]  s_left_stick_x;
    logic [7:0]  s_left_stick_y;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_held_buttons;
    logic [15:0] m_pressed_edges;
    logic [15:0] m_pressed_with_repeat;
    logic [15:0] m_virtual_held;
    logic [15:0] m_virtual_edges;
    logic [15:0] m_virtual_with_repeat;
    logic [7:0]  m_out_right_x;
    logic [7:0]  m_out_right_y;
    logic [7:0]  m_out_left_x;
    logic [7:0]  m_out_left_y;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    // Predictor state and registers
    logic [15:0] last_held;
    logic [15:0] last_virtual;
    logic [7:0]  repeat_timer [16];
    logic [7:0]  rpt_delay;
    logic [7:0]  rpt_period;
    logic [7:0]  stick_high;
    logic [7:0]  stick_low;

    result_t pending_results [$];
    frame_t  last_frame;
    int      run_left;
    int      sender_gap_pct;
    int      recv_stall_pct;
    int      cycle_count = 0;
    int      frames_sent;
    int      results_checked = 0;
    int      mismatch_count = 0;
    int      settings_used;

    gamepad_button_edge_autorepeat DUT (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_read_status         (s_read_status),
        .s_pad_kind            (s_pad_kind),
        .s_button_high_byte    (s_button_high_byte),
        .s_button_low_byte     (s_button_low_byte),
        .s_right_stick_x       (s_right_stick_x),
        .s_right_stick_y       (s_right_stick_y),
        .s_left_stick_x        (s_left_stick_x),
        .s_left_stick_y        (s_left_stick_y),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_held_buttons        (m_held_buttons),
        .m_pressed_edges       (m_pressed_edges),
        .m_pressed_with_repeat (m_pressed_with_repeat),
        .m_virtual_held        (m_virtual_held),
        .m_virtual_edges       (m_virtual_edges),
        .m_virtual_with_repeat (m_virtual_with_repeat),
        .m_out_right_x         (m_out_right_x),
        .m_out_right_y         (m_out_right_y),
        .m_out_left_x          (m_out_left_x),
        .m_out_left_y          (m_out_left_y),
        .cfg_wr_en             (cfg_wr_en),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // One repeat timer step; returns the pulse
    function automatic logic tick_repeat(int t, logic press, logic hold);
        logic fire;
        fire = 1'b0;
        if (press) begin
            repeat_timer[t] = rpt_delay;
        end else if (hold) begin
            repeat_timer[t] = repeat_timer[t] - 8'd1;
            if (repeat_timer[t] == 8'd0) begin
                fire            = 1'b1;
                repeat_timer[t] = rpt_period;
            end
        end
        return fire;
    endfunction

    // Expected result of one frame; advances the history and timers
    function automatic result_t decode_pad_frame(frame_t f);
        logic        analog;
        logic        digital;
        logic [15:0] prev;
        logic [15:0] vprev;
        int          pos;
        result_t     r;
        analog  = (f.status == 8'd0) &&
                  (f.kind == gpbe_pkg::PAD_ANALOG_S || f.kind == gpbe_pkg::PAD_ANALOG_Y);
        digital = analog || ((f.status == 8'd0) && f.kind == gpbe_pkg::PAD_DIGITAL);
        prev    = digital ? last_held : 16'h0000;
        r.held  = digital ? ~{f.btn_hi, f.btn_lo} : 16'h0000;
        vprev   = analog ? last_virtual : 16'h0000;
        r.rx    = analog ? f.rx : gpbe_pkg::STICK_NEUTRAL;
        r.ry    = analog ? f.ry : gpbe_pkg::STICK_NEUTRAL;
        r.lx    = analog ? f.lx : gpbe_pkg::STICK_NEUTRAL;
        r.ly    = analog ? f.ly : gpbe_pkg::STICK_NEUTRAL;

        // virtual d-pad: physical directions plus left stick thresholds
        r.vheld = r.held & gpbe_pkg::DPAD_MASK;
        if (r.lx > stick_high) r.vheld[gpbe_pkg::DirRightBit] = 1'b1;
        if (r.lx < stick_low)  r.vheld[gpbe_pkg::DirLeftBit]  = 1'b1;
        if (r.ly > stick_high) r.vheld[gpbe_pkg::DirDownBit]  = 1'b1;
        if (r.ly < stick_low)  r.vheld[gpbe_pkg::DirUpBit]    = 1'b1;

        r.edges  = r.held & ~prev;
        r.vedges = r.vheld & ~vprev;
        r.rep    = r.edges;
        r.vrep   = r.vedges;

        // direction timers run a second pass on the virtual bits
        for (int t = 0; t < gpbe_pkg::RepeatButtons; t++) begin
            pos = REPEAT_POS[t];
            if (tick_repeat(t, r.edges[pos], r.held[pos])) r.rep[pos] = 1'b1;
            if (t < gpbe_pkg::DirTimers && tick_repeat(t, r.vedges[pos], r.vheld[pos]))
                r.vrep[pos] = 1'b1;
        end

        last_held    = r.held;
        last_virtual = r.vheld;
        return r;
    endfunction

    // New stick position: keep, nudge, jump to an end or near a threshold, or anywhere
    function automatic logic [7:0] stick_pick(logic [7:0] v);
        int r;
        r = $urandom_range(99);
        if (r < 60) return v;
        if (r < 80) return v + 8'($urandom_range(16)) - 8'd8;
        if (r < 92) begin
            case ($urandom_range(5))
                0: return 8'd0;
                1: return 8'd255;
                2: return stick_high;
                3: return stick_high + 8'd1;
                4: return stick_low;
                default: return stick_low - 8'd1;
            endcase
        end
        return 8'($urandom);
    endfunction

    // Mostly valid frames with persistent buttons, steady runs, some noise
    function automatic frame_t roll_pad_frame();
        frame_t      f;
        logic [15:0] word;
        int          r;
        int          cap;
        if (run_left > 0) begin
            run_left--;
            return last_frame;
        end
        f = last_frame;
        if ($urandom_range(99) < 8) begin
            f = frame_t'({$urandom, $urandom});
        end else begin
            f.status = ($urandom_range(99) < 94) ? 8'h00 : 8'($urandom);
            if ($urandom_range(99) < 5) begin
                f.kind = 8'($urandom);
            end else begin
                case ($urandom_range(2))
                    0: f.kind = gpbe_pkg::PAD_DIGITAL;
                    1: f.kind = gpbe_pkg::PAD_ANALOG_S;
                    default: f.kind = gpbe_pkg::PAD_ANALOG_Y;
                endcase
            end
            word = {f.btn_hi, f.btn_lo};
            r = $urandom_range(99);
            if (r >= 90) begin
                word = 16'($urandom);
            end else if (r >= 65) begin
                word[$urandom_range(15)] ^= 1'b1;
                if ($urandom_range(1) == 1) word[$urandom_range(15)] ^= 1'b1;
            end
            {f.btn_hi, f.btn_lo} = word;
            f.rx = stick_pick(f.rx);
            f.ry = stick_pick(f.ry);
            f.lx = stick_pick(f.lx);
            f.ly = stick_pick(f.ly);
            // hold a good frame long enough to see repeat pulses
            if (f.status == 8'h00 && $urandom_range(99) < 3) begin
                cap = int'(rpt_delay) + 2 * int'(rpt_period) + 4;
                if (cap > 300) cap = 300;
                run_left = $urandom_range(cap, 1);
            end
        end
        last_frame = f;
        return f;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at result %0d: %s", results_checked, msg);
    endtask

    task automatic check_result(input result_t got, input result_t want);
        if (got.held !== want.held)
            report_mismatch($sformatf("held_buttons %h, want %h", got.held, want.held));
        if (got.edges !== want.edges)
            report_mismatch($sformatf("pressed_edges %h, want %h", got.edges, want.edges));
        if (got.rep !== want.rep)
            report_mismatch($sformatf("pressed_with_repeat %h, want %h", got.rep, want.rep));
        if (got.vheld !== want.vheld)
            report_mismatch($sformatf("virtual_held %h, want %h", got.vheld, want.vheld));
        if (got.vedges !== want.vedges)
            report_mismatch($sformatf("virtual_edges %h, want %h", got.vedges, want.vedges));
        if (got.vrep !== want.vrep)
            report_mismatch($sformatf("virtual_with_repeat %h, want %h", got.vrep, want.vrep));
        if (got.rx !== want.rx)
            report_mismatch($sformatf("out_right_x %h, want %h", got.rx, want.rx));
        if (got.ry !== want.ry)
            report_mismatch($sformatf("out_right_y %h, want %h", got.ry, want.ry));
        if (got.lx !== want.lx)
            report_mismatch($sformatf("out_left_x %h, want %h", got.lx, want.lx));
        if (got.ly !== want.ly)
            report_mismatch($sformatf("out_left_y %h, want %h", got.ly, want.ly));
    endtask

    // Offer one frame request, wait for the handshake, queue its result
    task automatic send_frame(input frame_t f, input logic typed, input result_t fixed);
        result_t want;
        while (sender_gap_pct > 0 && $urandom_range(99) < sender_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_read_status      <= f.status;
        s_pad_kind         <= f.kind;
        s_button_high_byte <= f.btn_hi;
        s_button_low_byte  <= f.btn_lo;
        s_right_stick_x    <= f.rx;
        s_right_stick_y    <= f.ry;
        s_left_stick_x     <= f.lx;
        s_left_stick_y     <= f.ly;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want = decode_pad_frame(f);
        if (typed) want = fixed;
        pending_results.push_back(want);
        frames_sent++;
    endtask

    task automatic wait_for_drain();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        case (idx)
            gpbe_pkg::CFG_REPEAT_DELAY:  rpt_delay  = value;
            gpbe_pkg::CFG_REPEAT_PERIOD: rpt_period = value;
            gpbe_pkg::CFG_STICK_HIGH:    stick_high = value;
            gpbe_pkg::CFG_STICK_LOW:     stick_low  = value;
            default: ;
        endcase
    endtask

    task automatic load_registers(input reg_set_t rs);
        write_reg(gpbe_pkg::CFG_REPEAT_DELAY, rs.delay);
        write_reg(gpbe_pkg::CFG_REPEAT_PERIOD, rs.period);
        write_reg(gpbe_pkg::CFG_STICK_HIGH, rs.high);
        write_reg(gpbe_pkg::CFG_STICK_LOW, rs.low);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            IDLE_SENDER: begin
                sender_gap_pct = 87;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                sender_gap_pct = 0;
                recv_stall_pct = 87;
            end
            IDLE_BOTH: begin
                sender_gap_pct = 25;
                recv_stall_pct = 25;
            end
            default: begin
                sender_gap_pct = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // Result side: check on each handshake, then pick the next ready
    initial begin : result_monitor
        result_t got;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got = '{m_held_buttons, m_pressed_edges, m_pressed_with_repeat,
                        m_virtual_held, m_virtual_edges, m_virtual_with_repeat,
                        m_out_right_x, m_out_right_y, m_out_left_x, m_out_left_y};
                if (pending_results.size() == 0)
                    report_mismatch("result with nothing expected");
                else
                    check_result(got, pending_results.pop_front());
                results_checked++;
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("[gamepad_button_edge_autorepeat] ERROR");
        $finish;
    end

    initial begin : stimulus
        reg_set_t rs;
        frame_t   f;
        frames_sent     = 0;
        settings_used   = 1;
        run_left        = 0;
        last_frame      = PRESS_ALL;
        last_held       = 16'h0000;
        last_virtual    = 16'h0000;
        for (int t = 0; t < 16; t++) repeat_timer[t] = 8'd0;
        rpt_delay  = gpbe_pkg::RESET_DELAY;
        rpt_period = gpbe_pkg::RESET_PERIOD;
        stick_high = gpbe_pkg::RESET_STICK_HIGH;
        stick_low  = gpbe_pkg::RESET_STICK_LOW;
        set_idle(IDLE_NONE);

        aresetn            <= 1'b0;
        s_valid            <= 1'b0;
        s_read_status      <= 8'h00;
        s_pad_kind         <= 8'h00;
        s_button_high_byte <= 8'hFF;
        s_button_low_byte  <= 8'hFF;
        s_right_stick_x    <= gpbe_pkg::STICK_NEUTRAL;
        s_right_stick_y    <= gpbe_pkg::STICK_NEUTRAL;
        s_left_stick_x     <= gpbe_pkg::STICK_NEUTRAL;
        s_left_stick_y     <= gpbe_pkg::STICK_NEUTRAL;
        cfg_wr_en          <= 1'b0;
        cfg_index          <= gpbe_pkg::CFG_REPEAT_DELAY;
        cfg_data           <= 8'h00;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed frames at the reset register values
        for (int n = 0; n < DIRECTED_COUNT; n++)
            send_frame(DIRECTED_ROWS[n].f, DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].r);

        // random frames, one register setting and idle pattern per phase
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                s_valid <= 1'b0;
                wait_for_drain();
                rs = REG_PHASES[p];
                if (p == RANDOM_PHASE) begin
                    rs.delay  = 8'($urandom_range(255, 1));
                    rs.period = 8'($urandom_range(255, 1));
                    rs.high   = 8'($urandom);
                    rs.low    = 8'($urandom);
                end
                load_registers(rs);
                run_left = 0;
            end
            set_idle(p % 4);
            for (int n = 0; n < FRAMES_PER_SET; n++) begin
                f = roll_pad_frame();
                send_frame(f, 1'b0, UNTYPED);
            end
        end
        s_valid <= 1'b0;
        wait_for_drain();
        repeat (10) @(posedge aclk);

        $display("sent %0d frames (%0d directed) over %0d register settings",
                 frames_sent, DIRECTED_COUNT, settings_used);
        $display("and four idle patterns; checked %0d results, %0d field mismatches",
                 results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("[gamepad_button_edge_autorepeat] OK");
        end else begin
            $display("[gamepad_button_edge_autorepeat] ERROR");
        end
        $finish;
    end

endmodule
